// ===== rtl/core/mdf_pkg.sv =====
// mdf_pkg: shared types and constants of the media stream deframer
// no dependencies; used by the channel interfaces and the top level
package mdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int MSG_ID_W = 16;
    localparam int CODEC_W  = 2;
    localparam int DIM_W    = 11;
    localparam int HPOS_W   = 5;
    localparam int SIZE_W   = 32;
    localparam int FLEFT_W  = 34;

    localparam logic [BYTE_W-1:0]   SYNC_BYTE      = 8'hFF;
    localparam logic [HPOS_W-1:0]   HDR_LEN        = 5'd20;
    localparam logic [HPOS_W-1:0]   HDR_ID_LO      = 5'd14;
    localparam logic [HPOS_W-1:0]   HDR_ID_HI      = 5'd15;
    localparam logic [HPOS_W-1:0]   HDR_LEN_B0     = 5'd16;
    localparam logic [HPOS_W-1:0]   HDR_LEN_B1     = 5'd17;
    localparam logic [HPOS_W-1:0]   HDR_LEN_B2     = 5'd18;
    localparam logic [HPOS_W-1:0]   HDR_LEN_B3     = 5'd19;
    localparam logic [HPOS_W-1:0]   MHDR_POS_MAX   = 5'd31;
    localparam logic [MSG_ID_W-1:0] VIDEO_ID_RESET = 16'd1412;

    // media frame type words
    localparam logic [SIZE_W-1:0] FT_I     = 32'h0000_01FC;
    localparam logic [SIZE_W-1:0] FT_P     = 32'h0000_01FD;
    localparam logic [SIZE_W-1:0] FT_JPEG  = 32'h0000_01FE;
    localparam logic [SIZE_W-1:0] FT_SOUND = 32'h0000_01FA;
    localparam logic [SIZE_W-1:0] FT_INFO  = 32'h0000_01F9;

    localparam logic [SIZE_W-1:0] MIN_SHORT_HDR = 32'd8;
    localparam logic [SIZE_W-1:0] MIN_LONG_HDR  = 32'd16;

    localparam logic KIND_VIDEO = 1'b0;
    localparam logic KIND_CTRL  = 1'b1;

    typedef struct packed {
        logic video;
        logic key;
        logic emit;
        logic drop;
        logic seen;
        logic open;
    } t_frame_flags;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic                frame_start;
        logic                frame_end;
        logic                key_frame;
        logic [MSG_ID_W-1:0] message_id;
        logic [CODEC_W-1:0]  codec;
        logic [BYTE_W-1:0]   frame_rate;
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
    } t_result;

endpackage

// ===== rtl/core/mdf_in_if.sv =====
// mdf_in_if: received byte channel, valid/ready handshake
// depends on mdf_pkg for the field width
interface mdf_in_if;
    logic                         valid;
    logic                         ready;
    logic [mdf_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/mdf_out_if.sv =====
// mdf_out_if: deframed result channel, valid/ready handshake
// depends on mdf_pkg for the field widths
interface mdf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [mdf_pkg::BYTE_W-1:0]     payload_byte;
    logic                           frame_start;
    logic                           frame_end;
    logic                           key_frame;
    logic [mdf_pkg::MSG_ID_W-1:0]   message_id;
    logic [mdf_pkg::CODEC_W-1:0]    codec;
    logic [mdf_pkg::BYTE_W-1:0]     frame_rate;
    logic [mdf_pkg::DIM_W-1:0]      frame_width;
    logic [mdf_pkg::DIM_W-1:0]      frame_height;

    modport source (
        output valid, output kind, output payload_byte, output frame_start,
        output frame_end, output key_frame, output message_id, output codec,
        output frame_rate, output frame_width, output frame_height,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input frame_start,
        input frame_end, input key_frame, input message_id, input codec,
        input frame_rate, input frame_width, input frame_height,
        output ready
    );
endinterface

// ===== rtl/core/mdf_cfg_if.sv =====
// mdf_cfg_if: configuration write channel for the video message id
// depends on mdf_pkg for the field width
interface mdf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mdf_pkg::MSG_ID_W-1:0]   video_message_id;

    modport source (output valid, output video_message_id, input ready);
    modport sink   (input valid, input video_message_id, output ready);
endinterface

// ===== rtl/core/media_stream_deframer.sv =====
// media_stream_deframer: byte-serial deframer for a sync-byte, length-prefixed stream
// depends on mdf_pkg and the interfaces mdf_in_if, mdf_out_if, mdf_cfg_if
//
// One received byte is taken per word on i_in, one every clock cycle while i_in.ready is high. The block hunts
// for the sync byte 0xFF, collects a 20-byte packet header (message id at bytes 14-15,
// little-endian payload length at 16-19) and then walks the payload. Payloads whose
// message id matches the video message id register carry media frames: the type word
// and the I/JPEG/P/audio/info headers are parsed, short or unknown packets are dropped,
// and video body bytes leave on o_out (kind 0), held back until the first key frame
// body byte. All other payloads leave unchanged as control bytes (kind 1). Each byte
// yields zero or one result word, which is registered in the output register, or in a
// second result register while the output register holds a stalled word, so i_in.ready
// only drops while both result registers hold words. A byte is handled by the header
// counter and the per-byte compares; the id register is written on i_cfg (always ready)
// and resets to 1412.
module media_stream_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mdf_in_if.sink              i_in,
    mdf_out_if.source           o_out,
    mdf_cfg_if.sink             i_cfg
);

    // configuration
    logic [mdf_pkg::MSG_ID_W-1:0]   r_vid_id;

    // packet framing state
    logic [mdf_pkg::HPOS_W-1:0]     r_hdr_pos,     n_hdr_pos;
    logic [mdf_pkg::MSG_ID_W-1:0]   r_msg_id,      n_msg_id;
    logic [mdf_pkg::SIZE_W-1:0]     r_pkt_size,    n_pkt_size;
    logic [mdf_pkg::SIZE_W-1:0]     r_pkt_left,    n_pkt_left;

    // media header and frame state
    logic [mdf_pkg::HPOS_W-1:0]     r_mhdr_pos,    n_mhdr_pos;
    logic [mdf_pkg::SIZE_W-1:0]     r_type_word,   n_type_word;
    logic [mdf_pkg::SIZE_W-1:0]     r_len_acc,     n_len_acc;
    logic signed [mdf_pkg::FLEFT_W-1:0] r_frame_left, n_frame_left;
    mdf_pkg::t_frame_flags          r_flags,       n_flags;
    logic                           r_got_key,     n_got_key;
    logic [mdf_pkg::CODEC_W-1:0]    r_codec,       n_codec;
    logic [mdf_pkg::BYTE_W-1:0]     r_rate,        n_rate;
    logic [mdf_pkg::BYTE_W-1:0]     r_width,       n_width;
    logic [mdf_pkg::BYTE_W-1:0]     r_height,      n_height;

    // result registers: output stage and skid stage
    logic                           r_out_valid;
    mdf_pkg::t_result               r_out;
    logic                           r_sk_valid;
    mdf_pkg::t_result               r_sk;

    logic                           in_fire;
    logic                           out_fire;
    logic                           res_valid;
    mdf_pkg::t_result               res;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // new bytes are taken as long as the skid stage is free
    assign i_in.ready  = !r_sk_valid;
    assign i_cfg.ready = 1'b1;

    // per-byte next state and result
    always_comb begin
        logic [mdf_pkg::BYTE_W-1:0]     b;
        logic                           first;
        logic                           last;
        logic [mdf_pkg::HPOS_W-1:0]     base_pos;
        logic [mdf_pkg::SIZE_W-1:0]     base_tw;
        logic [mdf_pkg::SIZE_W-1:0]     la;
        logic [mdf_pkg::SIZE_W-1:0]     lane_byte;
        logic                           ij;
        logic                           pf;
        logic                           af;
        logic                           key;
        logic                           done;
        logic signed [mdf_pkg::FLEFT_W-1:0] dec;
        logic                           closing;

        b         = i_in.rx_byte;
        first     = 1'b0;
        last      = 1'b0;
        base_pos  = '0;
        base_tw   = '0;
        la        = '0;
        lane_byte = {{(mdf_pkg::SIZE_W-mdf_pkg::BYTE_W){1'b0}}, b};
        ij        = 1'b0;
        pf        = 1'b0;
        af        = 1'b0;
        key       = 1'b0;
        done      = 1'b0;
        dec       = r_frame_left - 34'sd1;
        closing   = 1'b0;

        n_hdr_pos    = r_hdr_pos;
        n_msg_id     = r_msg_id;
        n_pkt_size   = r_pkt_size;
        n_pkt_left   = r_pkt_left;
        n_mhdr_pos   = r_mhdr_pos;
        n_type_word  = r_type_word;
        n_len_acc    = r_len_acc;
        n_frame_left = r_frame_left;
        n_flags      = r_flags;
        n_got_key    = r_got_key;
        n_codec      = r_codec;
        n_rate       = r_rate;
        n_width      = r_width;
        n_height     = r_height;

        res_valid          = 1'b0;
        res.kind           = mdf_pkg::KIND_CTRL;
        res.payload_byte   = b;
        res.frame_start    = 1'b0;
        res.frame_end      = 1'b0;
        res.key_frame      = 1'b0;
        res.message_id     = r_msg_id;
        res.codec          = r_codec;
        res.frame_rate     = r_rate;
        res.frame_width    = {r_width, 3'b000};
        res.frame_height   = {r_height, 3'b000};

        if (in_fire) begin
            if (r_hdr_pos == '0) begin
                // hunting for sync
                if (b == mdf_pkg::SYNC_BYTE) begin
                    n_hdr_pos = 5'd1;
                end
            end else if (r_hdr_pos < mdf_pkg::HDR_LEN) begin
                // packet header bytes
                case (r_hdr_pos)
                    mdf_pkg::HDR_ID_LO:  n_msg_id = {8'h00, b};
                    mdf_pkg::HDR_ID_HI:  n_msg_id = {b, r_msg_id[7:0]};
                    mdf_pkg::HDR_LEN_B0: n_pkt_size = lane_byte;
                    mdf_pkg::HDR_LEN_B1: n_pkt_size[15:8] = b;
                    mdf_pkg::HDR_LEN_B2: n_pkt_size[23:16] = b;
                    mdf_pkg::HDR_LEN_B3: n_pkt_size[31:24] = b;
                    default: ;
                endcase
                n_hdr_pos = r_hdr_pos + 5'd1;
                if (r_hdr_pos == mdf_pkg::HDR_LEN_B3) begin
                    n_pkt_left   = n_pkt_size;
                    n_flags.drop = 1'b0;
                    if (n_pkt_size == '0) begin
                        n_hdr_pos = '0;
                    end
                end
            end else begin
                // payload byte
                first = (r_pkt_left == r_pkt_size);
                last  = (r_pkt_left <= 32'd1);
                if (r_pkt_left != '0) begin
                    n_pkt_left = r_pkt_left - 32'd1;
                end

                if (r_msg_id != r_vid_id) begin
                    res_valid       = 1'b1;
                    res.kind        = mdf_pkg::KIND_CTRL;
                    res.frame_start = first;
                    res.frame_end   = last;
                end else if (r_flags.drop) begin
                    // rest of packet discarded
                end else if (!r_flags.open) begin
                    if (first && (r_pkt_size < mdf_pkg::MIN_SHORT_HDR)) begin
                        n_flags.drop = 1'b1;
                    end else begin
                        base_pos = first ? '0 : r_mhdr_pos;
                        base_tw  = first ? '0 : r_type_word;
                        la       = first ? '0 : r_len_acc;
                        n_mhdr_pos = (base_pos < mdf_pkg::MHDR_POS_MAX) ?
                                     base_pos + 5'd1 : base_pos;
                        if (base_pos < 5'd4) begin
                            // big-endian type word
                            n_type_word = {base_tw[23:0], b};
                            n_len_acc   = la;
                            if (base_pos == 5'd3) begin
                                ij = (n_type_word == mdf_pkg::FT_I) ||
                                     (n_type_word == mdf_pkg::FT_JPEG);
                                pf = (n_type_word == mdf_pkg::FT_P);
                                af = (n_type_word == mdf_pkg::FT_SOUND) ||
                                     (n_type_word == mdf_pkg::FT_INFO);
                                if (!(ij || pf || af) ||
                                    (ij && (r_pkt_size < mdf_pkg::MIN_LONG_HDR))) begin
                                    n_flags.drop = 1'b1;
                                end
                            end
                        end else begin
                            ij  = (base_tw == mdf_pkg::FT_I) ||
                                  (base_tw == mdf_pkg::FT_JPEG);
                            pf  = (base_tw == mdf_pkg::FT_P);
                            key = (base_tw == mdf_pkg::FT_I);
                            if (ij) begin
                                if ((base_pos == 5'd4) && (b >= 8'd1) && (b <= 8'd3)) begin
                                    n_codec = b[1:0];
                                end else if (base_pos == 5'd5) begin
                                    n_rate = b;
                                end else if (base_pos == 5'd6) begin
                                    n_width = b;
                                end else if (base_pos == 5'd7) begin
                                    n_height = b;
                                end else if ((base_pos >= 5'd12) && (base_pos <= 5'd15)) begin
                                    la = la | (lane_byte << {base_pos[1:0], 3'b000});
                                end
                                done = (base_pos >= 5'd15);
                            end else if (pf) begin
                                if (base_pos <= 5'd7) begin
                                    la = la | (lane_byte << {base_pos[1:0], 3'b000});
                                end
                                done = (base_pos >= 5'd7);
                            end else begin
                                // audio or info: 16-bit length at bytes 6-7
                                if ((base_pos == 5'd6) || (base_pos == 5'd7)) begin
                                    la = la | (lane_byte << {1'b0, base_pos[0], 3'b000});
                                end
                                done = (base_pos >= 5'd7);
                            end
                            n_type_word = base_tw;
                            n_len_acc   = la;
                            if (done) begin
                                n_flags       = '0;
                                n_flags.open  = 1'b1;
                                n_flags.video = ij || pf;
                                n_flags.key   = key;
                                n_flags.emit  = (ij || pf) && (key || r_got_key);
                                n_frame_left  = $signed({2'b00, la});
                                if (last && (la == '0)) begin
                                    n_flags      = '0;
                                    n_frame_left = '0;
                                end
                            end
                        end
                    end
                end else begin
                    // frame body byte
                    closing      = last && (dec[mdf_pkg::FLEFT_W-1] || (dec == '0));
                    n_frame_left = dec;
                    if (r_flags.key) begin
                        n_got_key = 1'b1;
                    end
                    if (r_flags.emit) begin
                        res_valid       = 1'b1;
                        res.kind        = mdf_pkg::KIND_VIDEO;
                        res.frame_start = !r_flags.seen;
                        res.frame_end   = closing;
                        res.key_frame   = r_flags.key;
                    end
                    n_flags.seen = 1'b1;
                    if (closing) begin
                        n_flags      = '0;
                        n_frame_left = '0;
                    end
                end

                if (last) begin
                    n_hdr_pos    = '0;
                    n_flags.drop = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vid_id     <= mdf_pkg::VIDEO_ID_RESET;
            r_hdr_pos    <= '0;
            r_msg_id     <= '0;
            r_pkt_size   <= '0;
            r_pkt_left   <= '0;
            r_mhdr_pos   <= '0;
            r_type_word  <= '0;
            r_len_acc    <= '0;
            r_frame_left <= '0;
            r_flags      <= '0;
            r_got_key    <= 1'b0;
            r_codec      <= '0;
            r_rate       <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_out_valid  <= 1'b0;
            r_sk_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_vid_id <= i_cfg.video_message_id;
            end
            r_hdr_pos    <= n_hdr_pos;
            r_msg_id     <= n_msg_id;
            r_pkt_size   <= n_pkt_size;
            r_pkt_left   <= n_pkt_left;
            r_mhdr_pos   <= n_mhdr_pos;
            r_type_word  <= n_type_word;
            r_len_acc    <= n_len_acc;
            r_frame_left <= n_frame_left;
            r_flags      <= n_flags;
            r_got_key    <= n_got_key;
            r_codec      <= n_codec;
            r_rate       <= n_rate;
            r_width      <= n_width;
            r_height     <= n_height;

            // output stage with skid: skid drains first, no new byte meanwhile
            if (r_sk_valid) begin
                if (out_fire) begin
                    r_out_valid <= 1'b1;
                    r_sk_valid  <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_sk_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (out_fire) begin
                r_out <= r_sk;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_sk <= res;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.frame_start  = r_out.frame_start;
    assign o_out.frame_end    = r_out.frame_end;
    assign o_out.key_frame    = r_out.key_frame;
    assign o_out.message_id   = r_out.message_id;
    assign o_out.codec        = r_out.codec;
    assign o_out.frame_rate   = r_out.frame_rate;
    assign o_out.frame_width  = r_out.frame_width;
    assign o_out.frame_height = r_out.frame_height;

    // skid stage only fills behind a full output stage
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid word without output word");

    // header bytes and hunting never produce a result
    a_no_result_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_hdr_pos != mdf_pkg::HDR_LEN)) |-> !res_valid)
        else $error("result produced outside payload");

    // an open frame is never in drop mode, and only video frames emit
    a_open_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.open |-> (!r_flags.drop && (!r_flags.emit || r_flags.video)))
        else $error("inconsistent frame flags");

    // key frame seen flag is sticky
    a_got_key_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_got_key))
        else $error("got_key cleared");

    // header position never passes the payload marker
    a_hdr_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pos <= mdf_pkg::HDR_LEN)
        else $error("header position out of range");

endmodule
